### rtl/assert_macros.svh
// assertion macros for the priority queue rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked at every edge outside reset
`define SPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(label, clk, rst, prop, msg)
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/spq_pkg.sv
// shared types and constants of the sorted priority queue
// no dependencies
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int MAX_RESULTS = 16;
   localparam int KEY_W = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_RANGE = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic occupied;
   } cell_ctl_type;

endpackage

### rtl/spq_cell.sv
// one storage cell of the sorted chain: key, value and local insert decision
// depends on spq_pkg
module spq_cell import spq_pkg::*; (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [KEY_W-1:0]   new_key,
   input  logic [VALUE_W-1:0] new_value,
   input  logic [KEY_W-1:0]   left_key,
   input  logic [VALUE_W-1:0] left_value,
   input  logic               left_keep,
   input  logic [KEY_W-1:0]   right_key,
   input  logic [VALUE_W-1:0] right_value,
   output logic [KEY_W-1:0]   key,
   output logic [VALUE_W-1:0] value,
   output logic               keep
);

   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;

   // an occupied entry stays put on insert when its key is not above the new one
   assign keep = ctl.occupied && (key_ff <= new_key);

   always_comb begin
      key_in = key_ff;
      value_in = value_ff;
      case (ctl.cmd)
         CELL_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  key_in = new_key;
                  value_in = new_value;
               end else begin
                  key_in = left_key;
                  value_in = left_value;
               end
            end
         end
         CELL_SHIFT: begin
            key_in = right_key;
            value_in = right_value;
         end
         default: begin
            key_in = key_ff;
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      value_ff <= value_in;
   end

   assign key = key_ff;
   assign value = value_ff;

endmodule

### rtl/sorted_priority_queue_top.sv
// top level of the sorted priority queue: control, result register, cell chain
// depends on spq_pkg, spq_cell and assert_macros.svh
//
// usage
// - request channel req_*: mode 0 insert, 1 remove smallest, 2 range query,
//   3 unused (answered with a failure); a request is taken when req_valid is
//   high and req_stall is low
// - result channel rsp_*: one result per insert, remove or unused mode; a
//   range query streams every matching entry in key order, or one failure
//   result when nothing matches; rsp_last marks the final result of a request
// - failures carry success 0, key 0, value 0 and last 1
// - insert and remove change the cell chain as the request is taken; the
//   result appears in the result register the cycle after the request is
//   taken; the next request can be taken in that cycle if rsp_stall is low
// - a range query rotates the whole ring of CAPACITY cells past cell 0 and
//   back, so it holds off requests until the ring is back in place and the
//   final result is registered, and longer while a result waits on rsp_stall
// - a result is held stable while rsp_stall is high; the chain pauses with it
// - synchronous reset empties the queue and drops any pending result; the
//   cell contents are not cleared, the entry count alone marks them in use
`include "assert_macros.svh"
module sorted_priority_queue_top import spq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [KEY_W-1:0]   req_item_key,
   input  logic [VALUE_W-1:0] req_item_value,
   input  logic [KEY_W-1:0]   req_range_high,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_success,
   output logic [KEY_W-1:0]   rsp_out_key,
   output logic [VALUE_W-1:0] rsp_out_value,
   output logic               rsp_last
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type          state_ff;
   logic [COUNT_W-1:0] entry_count_ff;
   logic [COUNT_W-1:0] scan_ff;
   logic [KEY_W-1:0]   range_low_ff, range_high_ff;
   logic [KEY_W-1:0]   pend_key_ff;
   logic [VALUE_W-1:0] pend_value_ff;
   logic               pend_have_ff;

   logic               rsp_valid_ff, rsp_success_ff, rsp_last_ff;
   logic [KEY_W-1:0]   rsp_key_ff;
   logic [VALUE_W-1:0] rsp_value_ff;

   logic               out_free, req_accept, full, empty, scan_done, head_match;
   cell_cmd_type       cell_cmd;

   logic [KEY_W-1:0]   cell_key   [CAPACITY];
   logic [VALUE_W-1:0] cell_value [CAPACITY];
   logic               cell_keep  [CAPACITY];

   // result register can take a new result this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;

   assign full = (entry_count_ff == COUNT_W'(CAPACITY));
   assign empty = (entry_count_ff == '0);
   assign scan_done = (scan_ff == COUNT_W'(CAPACITY));

   // cell 0 holds the entry at ring position scan_ff; only stored ones count
   assign head_match = (scan_ff < entry_count_ff)
                    && (cell_key[0] >= range_low_ff)
                    && (cell_key[0] <= range_high_ff);

   // chain command, same for every cell
   always_comb begin
      cell_cmd = CELL_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_mode == MODE_INSERT) && !full) begin
               cell_cmd = CELL_INSERT;
            end else if (req_accept && (req_mode == MODE_REMOVE) && !empty) begin
               cell_cmd = CELL_SHIFT;
            end
         end
         ST_SCAN: begin
            // rotation by one; CAPACITY steps bring the ring back in place
            if (out_free && !scan_done) begin
               cell_cmd = CELL_SHIFT;
            end
         end
         default: cell_cmd = CELL_HOLD;
      endcase
   end

   // ring of cells: each takes its left neighbour on insert, its right on shift
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int LEFT = (i == 0) ? 0 : i - 1;
      localparam int RIGHT = (i == CAPACITY - 1) ? 0 : i + 1;
      cell_ctl_type ctl;

      assign ctl.cmd = cell_cmd;
      assign ctl.occupied = (entry_count_ff > COUNT_W'(i));

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .new_key     (req_item_key),
         .new_value   (req_item_value),
         // front cell sees the new entry as its left neighbour
         .left_key    ((i == 0) ? req_item_key : cell_key[LEFT]),
         .left_value  ((i == 0) ? req_item_value : cell_value[LEFT]),
         .left_keep   ((i == 0) ? 1'b1 : cell_keep[LEFT]),
         .right_key   (cell_key[RIGHT]),
         .right_value (cell_value[RIGHT]),
         .key         (cell_key[i]),
         .value       (cell_value[i]),
         .keep        (cell_keep[i])
      );
   end

   // control state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         entry_count_ff <= '0;
         scan_ff <= '0;
         pend_have_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  // default answer is a failure
                  rsp_valid_ff <= 1'b1;
                  rsp_success_ff <= 1'b0;
                  rsp_key_ff <= '0;
                  rsp_value_ff <= '0;
                  rsp_last_ff <= 1'b1;
                  case (req_mode)
                     MODE_INSERT: begin
                        if (!full) begin
                           rsp_success_ff <= 1'b1;
                           rsp_key_ff <= req_item_key;
                           rsp_value_ff <= req_item_value;
                           entry_count_ff <= entry_count_ff + COUNT_W'(1);
                        end
                     end
                     MODE_REMOVE: begin
                        if (!empty) begin
                           rsp_success_ff <= 1'b1;
                           rsp_key_ff <= cell_key[0];
                           rsp_value_ff <= cell_value[0];
                           entry_count_ff <= entry_count_ff - COUNT_W'(1);
                        end
                     end
                     MODE_RANGE: begin
                        // results come from the scan instead
                        rsp_valid_ff <= 1'b0;
                        state_ff <= ST_SCAN;
                        scan_ff <= '0;
                        pend_have_ff <= 1'b0;
                        range_low_ff <= req_item_key;
                        range_high_ff <= req_range_high;
                     end
                     default: begin
                        rsp_success_ff <= 1'b0;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (out_free) begin
                  if (scan_done) begin
                     // held match is the final one, or nothing matched
                     rsp_valid_ff <= 1'b1;
                     rsp_success_ff <= pend_have_ff;
                     rsp_key_ff <= pend_have_ff ? pend_key_ff : '0;
                     rsp_value_ff <= pend_have_ff ? pend_value_ff : '0;
                     rsp_last_ff <= 1'b1;
                     pend_have_ff <= 1'b0;
                     state_ff <= ST_IDLE;
                  end else begin
                     scan_ff <= scan_ff + COUNT_W'(1);
                     if (head_match) begin
                        // a later match proves the held one is not the last
                        if (pend_have_ff) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_success_ff <= 1'b1;
                           rsp_key_ff <= pend_key_ff;
                           rsp_value_ff <= pend_value_ff;
                           rsp_last_ff <= 1'b0;
                        end
                        pend_key_ff <= cell_key[0];
                        pend_value_ff <= cell_value[0];
                        pend_have_ff <= 1'b1;
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_success = rsp_success_ff;
   assign rsp_out_key = rsp_key_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last = rsp_last_ff;

   // checks; the count is unknown until the first reset edge
   `SPQ_ASSERT_ALWAYS(a_count_bound, clock,
      reset || (entry_count_ff <= COUNT_W'(CAPACITY)), "entry count above capacity")
   `SPQ_ASSERT(a_scan_blocks_req, clock, reset,
      (state_ff == ST_SCAN) |-> req_stall, "request taken during range scan")
   `SPQ_ASSERT(a_fail_is_last, clock, reset,
      (rsp_valid && !rsp_success) |-> (rsp_last && (rsp_out_key == '0)),
      "failure result not final or not cleared")
   `SPQ_ASSERT(a_remove_count, clock, reset,
      (req_accept && (req_mode == MODE_REMOVE) && !empty)
         |=> (entry_count_ff == $past(entry_count_ff) - COUNT_W'(1)),
      "remove did not drop the entry count")

endmodule
